// File: rtl/csvp_pkg.sv
package csvp_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] MARK0    = 8'hEF;
  localparam logic [7:0] MARK1    = 8'hBB;
  localparam logic [7:0] MARK2    = 8'hBF;

  // Byte order mark progress
  localparam logic [1:0] BOM_START = 2'd0;
  localparam logic [1:0] BOM_EF    = 2'd1;
  localparam logic [1:0] BOM_EFBB  = 2'd2;
  localparam logic [1:0] BOM_PAST  = 2'd3;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  typedef enum logic [1:0] {
    TK_DATA  = 2'd0,
    TK_FIELD = 2'd1,
    TK_ROW   = 2'd2,
    TK_ERROR = 2'd3
  } token_kind_t;

  typedef struct packed {
    logic [1:0] bom_stage;
    logic       inside_quotes;
    logic       quote_pending;
    logic       cr_pending;
    logic       field_quoted;
    logic       field_nonempty;
    logic       row_nonempty;
  } parse_state_t;

  typedef struct packed {
    token_kind_t kind;
    logic [7:0]  data;
  } token_t;

  // Tokens produced by one input transaction, in delivery order
  typedef struct packed {
    logic [1:0]       count;
    token_t [2:0]     toks;
  } step_t;

  typedef struct packed {
    parse_state_t st;
    logic         emit;
    token_t       tok;
  } take_t;

  // One text byte against the field and row state; gives at most one token.
  function automatic take_t take_byte(parse_state_t s, logic [7:0] b);
    take_t r;
    logic  done;
    r.st   = s;
    r.emit = 1'b0;
    r.tok  = '{kind: TK_DATA, data: 8'h00};
    done   = 1'b0;
    if (r.st.cr_pending) begin
      r.st.cr_pending = 1'b0;
      if (b == CH_LF) begin
        done = 1'b1;
      end
    end
    if (!done) begin
      if (r.st.quote_pending) begin
        r.st.quote_pending = 1'b0;
        if (b == CH_QUOTE) begin
          r.emit = 1'b1;
          r.tok  = '{kind: TK_DATA, data: CH_QUOTE};
          r.st.field_nonempty = 1'b1;
          done = 1'b1;
        end else begin
          r.st.inside_quotes = 1'b0;
        end
      end else if (r.st.inside_quotes) begin
        if (b == CH_QUOTE) begin
          r.st.quote_pending = 1'b1;
        end else begin
          r.emit = 1'b1;
          r.tok  = '{kind: TK_DATA, data: b};
          r.st.field_nonempty = 1'b1;
        end
        done = 1'b1;
      end
    end
    if (!done) begin
      if (b == CH_QUOTE && !r.st.field_nonempty && !r.st.field_quoted) begin
        r.st.inside_quotes = 1'b1;
        r.st.field_quoted  = 1'b1;
      end else if (b == CH_COMMA) begin
        r.emit = 1'b1;
        r.tok  = '{kind: TK_FIELD, data: 8'h00};
        r.st.field_nonempty = 1'b0;
        r.st.field_quoted   = 1'b0;
        r.st.row_nonempty   = 1'b1;
      end else if (b inside {CH_CR, CH_LF}) begin
        r.emit = 1'b1;
        r.tok  = '{kind: TK_ROW, data: 8'h00};
        r.st.field_nonempty = 1'b0;
        r.st.field_quoted   = 1'b0;
        r.st.row_nonempty   = 1'b0;
        r.st.cr_pending     = (b == CH_CR);
      end else begin
        r.emit = 1'b1;
        r.tok  = '{kind: TK_DATA, data: b};
        r.st.field_nonempty = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/csvp_core.sv
module csvp_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic                cmd,
  input  logic [7:0]          byte_in,
  output csvp_pkg::step_t     step
);

  csvp_pkg::parse_state_t state;
  csvp_pkg::parse_state_t state_next;

  always_comb begin
    csvp_pkg::parse_state_t st;
    csvp_pkg::take_t        r;
    logic [1:0]             held;
    logic [1:0]             n;
    logic                   replay;
    st         = state;
    r          = '0;
    n          = 2'd0;
    step.toks  = '0;
    replay     = 1'b0;
    if (cmd == csvp_pkg::CMD_BYTE) begin
      if (st.bom_stage == csvp_pkg::BOM_START && byte_in == csvp_pkg::MARK0) begin
        st.bom_stage = csvp_pkg::BOM_EF;
      end else if (st.bom_stage == csvp_pkg::BOM_EF && byte_in == csvp_pkg::MARK1) begin
        st.bom_stage = csvp_pkg::BOM_EFBB;
      end else if (st.bom_stage == csvp_pkg::BOM_EFBB && byte_in == csvp_pkg::MARK2) begin
        st.bom_stage = csvp_pkg::BOM_PAST;
      end else begin
        replay = 1'b1;
      end
    end else begin
      replay = 1'b1;
    end

    // Replay held mark bytes as ordinary text
    held = st.bom_stage;
    if (replay) begin
      st.bom_stage = csvp_pkg::BOM_PAST;
      if (held == csvp_pkg::BOM_EF || held == csvp_pkg::BOM_EFBB) begin
        r  = csvp_pkg::take_byte(st, csvp_pkg::MARK0);
        st = r.st;
        if (r.emit) begin
          step.toks[n] = r.tok;
          n = n + 2'd1;
        end
      end
      if (held == csvp_pkg::BOM_EFBB) begin
        r  = csvp_pkg::take_byte(st, csvp_pkg::MARK1);
        st = r.st;
        if (r.emit) begin
          step.toks[n] = r.tok;
          n = n + 2'd1;
        end
      end
    end

    if (cmd == csvp_pkg::CMD_BYTE) begin
      if (replay) begin
        r  = csvp_pkg::take_byte(st, byte_in);
        st = r.st;
        if (r.emit) begin
          step.toks[n] = r.tok;
          n = n + 2'd1;
        end
      end
    end else begin
      // A trailing quote inside quotes closes the section
      if (st.quote_pending) begin
        st.quote_pending = 1'b0;
        st.inside_quotes = 1'b0;
      end
      if (st.inside_quotes) begin
        step.toks[n] = '{kind: csvp_pkg::TK_ERROR, data: 8'h00};
        n = n + 2'd1;
      end else if (st.field_nonempty || st.row_nonempty || st.field_quoted) begin
        step.toks[n] = '{kind: csvp_pkg::TK_ROW, data: 8'h00};
        n = n + 2'd1;
      end
      st = '0;
    end
    step.count = n;
    state_next = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/csvp_out.sv
module csvp_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  csvp_pkg::step_t   step,
  output logic              can_load,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // out_byte
  output logic [1:0]        m_axis_tuser,   // token_kind
  output logic              m_axis_tlast    // last_of_run
);

  csvp_pkg::token_t [2:0] toks;
  logic [1:0]             cnt;
  logic [1:0]             idx;
  logic                   busy;
  logic                   at_last;
  logic                   m_fire;

  assign at_last       = (idx == cnt - 2'd1);
  assign m_fire        = busy && m_axis_tready;
  assign can_load      = !busy || (m_fire && at_last);
  assign m_axis_tvalid = busy;
  assign m_axis_tdata  = toks[idx].data;
  assign m_axis_tuser  = toks[idx].kind;
  assign m_axis_tlast  = at_last;

  always_ff @(posedge clk) begin
    if (load) begin
      toks <= step.toks;
      cnt  <= step.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (m_fire) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

// File: rtl/csv_byte_stream_parser.sv
// CSV byte stream parser.
// Slave channel s_axis: one transaction per text byte (tuser = 0, byte in
// tdata) or one end-of-text marker (tuser = 1, tdata ignored).
// Master channel m_axis: tokens. tuser is the kind (0 data byte, 1 field
// end, 2 field and row end, 3 unterminated quote error), tdata the content
// byte for data tokens and zero otherwise, tlast marks the final token that
// one input transaction produced. A transaction may produce no token.
// Each accepted transaction is registered in the input register; its tokens
// are then loaded into the result register, which drives m_axis.
// Throughput: one input transaction per cycle while each yields at most one
// token and the receiver is ready; a transaction yielding several tokens
// holds the result register until each has passed the single token port.
// A stalled receiver holds the current token; the input register keeps its
// item and s_axis_tready drops until the result register frees.
// Reset (rst, synchronous) clears the parser state and drops any held item
// and pending tokens; s_axis_tready stays low while rst is high and the
// block is ready in the first cycle after reset.
module csv_byte_stream_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // text_byte
  input  logic       s_axis_tuser,   // cmd
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_byte
  output logic [1:0] m_axis_tuser,   // token_kind
  output logic       m_axis_tlast    // last_of_run
);

  logic            in_valid;
  logic            in_cmd;
  logic [7:0]      in_byte;
  logic            consume;
  logic            can_load;
  csvp_pkg::step_t step;

  // Advance when the item yields nothing or the result register can take it
  assign consume       = in_valid && (step.count == 2'd0 || can_load);
  assign s_axis_tready = !rst && (!in_valid || consume);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd  <= s_axis_tuser;
      in_byte <= s_axis_tdata;
    end
  end

  csvp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (consume),
    .cmd     (in_cmd),
    .byte_in (in_byte),
    .step    (step)
  );

  csvp_out u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (consume && step.count != 2'd0),
    .step          (step),
    .can_load      (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
